// ===== hdl/owbm_pkg.sv =====
// Shared types and timing constants for the one-wire byte master.
package owbm_pkg;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_kind_t;

  localparam int TIMER_W = 10;

  localparam logic [TIMER_W-1:0] RST_LOW_TICKS   = 10'd500;
  localparam logic [TIMER_W-1:0] RST_WAIT_TICKS  = 10'd80;
  localparam logic [TIMER_W-1:0] RST_TAIL_TICKS  = 10'd250;
  localparam logic [TIMER_W-1:0] LONG_LOW_TICKS  = 10'd60;
  localparam logic [TIMER_W-1:0] SHORT_TICKS     = 10'd2;
  localparam logic [TIMER_W-1:0] READ_WAIT_TICKS = 10'd10;

  localparam logic [TIMER_W-1:0] SLOT_LAST   = SHORT_TICKS + LONG_LOW_TICKS - 10'd1;
  localparam logic [TIMER_W-1:0] RST_SAMPLE  = RST_LOW_TICKS + RST_WAIT_TICKS;
  localparam logic [TIMER_W-1:0] RST_LAST    = RST_SAMPLE + RST_TAIL_TICKS - 10'd1;
  localparam logic [TIMER_W-1:0] READ_SAMPLE = SHORT_TICKS + READ_WAIT_TICKS;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic       line_level;
  } req_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic       rejected;
  } res_t;

endpackage

// ===== hdl/owbm_req_if.sv =====
// Valid/ready channel that carries one tick request into the master.
interface owbm_req_if;
  logic               valid;
  logic               ready;
  owbm_pkg::req_t     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/owbm_res_if.sv =====
// Valid/ready channel that carries one tick result out of the master.
interface owbm_res_if;
  logic               valid;
  logic               ready;
  owbm_pkg::res_t     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/one_wire_byte_master_unit.sv =====
// Top level of the one-wire byte master: request register, step logic, result register.
// A request is held in the request register and then moves into the result register, where its result is shown valid.
// Throughput: one request (one bus tick) per clock cycle, sustained, while res.ready holds.
// The request register holds while a finished result waits: it advances whenever
// the result register is empty or being drained in the same cycle.
// Reset (synchronous, active high) empties both registers and returns the
// sequencer to idle with presence and the received byte cleared.
module one_wire_byte_master_unit (
  input  logic          clk,
  input  logic          rst,
  owbm_req_if.sink      req,
  owbm_res_if.source    res
);

  // Request register: one tick waiting for the step logic.
  logic            req_valid;
  owbm_pkg::req_t  req_data;

  // Result register.
  logic            res_valid;
  owbm_pkg::res_t  res_data;

  logic            advance;
  owbm_pkg::res_t  step_result;

  // Move the held request through the step logic when the result slot frees up.
  assign advance   = req_valid && (!res_valid || res.ready);
  assign req.ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.ready) begin
      req_valid <= req.valid;
    end
  end

  // Payload needs no reset; load on every accepted request.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_data <= req.payload;
    end
  end

  owbm_step u_step (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (req_data),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      // Drop the result once taken.
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= step_result;
    end
  end

  assign res.valid   = res_valid;
  assign res.payload = res_data;

endmodule

// ===== hdl/owbm_step.sv =====
// Bus sequencer state and the per-tick step logic of the one-wire master.
module owbm_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  owbm_pkg::req_t  item,
  output owbm_pkg::res_t  result
);

  owbm_pkg::op_kind_t                 op_kind, op_kind_next;
  logic [2:0]                         bit_index, bit_index_next;
  logic [owbm_pkg::TIMER_W-1:0]       slot_timer, slot_timer_next;
  logic [7:0]                         shift_byte, shift_byte_next;
  logic                               presence_flag, presence_flag_next;
  logic [7:0]                         rx_hold, rx_hold_next;

  owbm_pkg::op_kind_t                 op_eff;
  logic [owbm_pkg::TIMER_W-1:0]       t;
  logic [2:0]                         bi;
  logic [7:0]                         sb;
  logic                               start;
  logic                               slot_end;
  logic                               drive, done, rej;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_kind       <= owbm_pkg::OP_IDLE;
      bit_index     <= '0;
      slot_timer    <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      rx_hold       <= '0;
    end else if (en) begin
      op_kind       <= op_kind_next;
      bit_index     <= bit_index_next;
      slot_timer    <= slot_timer_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      rx_hold       <= rx_hold_next;
    end
  end

  always_comb begin
    start    = (op_kind == owbm_pkg::OP_IDLE) && (item.action != owbm_pkg::OP_IDLE);
    rej      = (op_kind != owbm_pkg::OP_IDLE) && (item.action != owbm_pkg::OP_IDLE);
    op_eff   = start ? owbm_pkg::op_kind_t'(item.action) : op_kind;
    t        = start ? '0 : slot_timer;
    bi       = start ? '0 : bit_index;
    if (start) begin
      sb = (owbm_pkg::op_kind_t'(item.action) == owbm_pkg::OP_WRITE) ? item.tx_byte : 8'd0;
    end else begin
      sb = shift_byte;
    end

    drive              = 1'b0;
    done               = 1'b0;
    slot_end           = 1'b0;
    op_kind_next       = op_eff;
    bit_index_next     = bi;
    slot_timer_next    = t;
    shift_byte_next    = sb;
    presence_flag_next = presence_flag;
    rx_hold_next       = rx_hold;

    unique case (op_eff)
      owbm_pkg::OP_IDLE: begin
        drive = 1'b0;
      end
      owbm_pkg::OP_RESET: begin
        drive = (t < owbm_pkg::RST_LOW_TICKS);
        if (t == owbm_pkg::RST_SAMPLE) begin
          presence_flag_next = ~item.line_level;
        end
        done = (t >= owbm_pkg::RST_LAST);
      end
      owbm_pkg::OP_WRITE: begin
        drive    = sb[0] ? (t < owbm_pkg::SHORT_TICKS) : (t < owbm_pkg::LONG_LOW_TICKS);
        slot_end = (t >= owbm_pkg::SLOT_LAST);
        if (slot_end) begin
          shift_byte_next = {1'b0, sb[7:1]};
        end
      end
      owbm_pkg::OP_READ: begin
        drive    = (t < owbm_pkg::SHORT_TICKS);
        slot_end = (t >= owbm_pkg::SLOT_LAST);
        // Sample point cannot coincide with the slot end.
        if (t == owbm_pkg::READ_SAMPLE) begin
          shift_byte_next = {item.line_level, sb[7:1]};
        end
      end
      default: begin
        drive = 1'b0;
      end
    endcase

    if (slot_end) begin
      if (bi >= owbm_pkg::LAST_BIT) begin
        done = 1'b1;
        if (op_eff == owbm_pkg::OP_READ) begin
          rx_hold_next = shift_byte_next;
        end
      end else begin
        bit_index_next = 3'(bi + 3'd1);
      end
    end

    if (done) begin
      op_kind_next    = owbm_pkg::OP_IDLE;
      bit_index_next  = '0;
      slot_timer_next = '0;
    end else if (slot_end) begin
      slot_timer_next = '0;
    end else if (op_eff != owbm_pkg::OP_IDLE) begin
      slot_timer_next = owbm_pkg::TIMER_W'(t + 10'd1);
    end

    result.drive_low = drive;
    result.busy_res  = (op_eff != owbm_pkg::OP_IDLE);
    result.done_res  = done;
    result.presence  = presence_flag_next;
    result.rx_byte   = rx_hold_next;
    result.rejected  = rej;
  end

  // An idle sequencer holds its counters at zero.
  assert property (@(posedge clk) disable iff (rst)
    (op_kind == owbm_pkg::OP_IDLE) |-> (bit_index == 3'd0 && slot_timer == '0))
    else $error("idle sequencer with live counters");

  // The timer never runs past the end of a reset.
  assert property (@(posedge clk) disable iff (rst)
    slot_timer <= owbm_pkg::RST_LAST)
    else $error("slot timer overran");

  // Bit slots never exceed their length.
  assert property (@(posedge clk) disable iff (rst)
    (op_kind == owbm_pkg::OP_WRITE || op_kind == owbm_pkg::OP_READ)
      |-> (slot_timer <= owbm_pkg::SLOT_LAST))
    else $error("bit slot overran");

  // Drive, done and reject only occur during an operation.
  assert property (@(posedge clk) disable iff (rst)
    en && (result.drive_low || result.done_res || result.rejected) |-> result.busy_res)
    else $error("bus activity outside an operation");

  // Completion returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (rst)
    en && result.done_res |=> (op_kind == owbm_pkg::OP_IDLE))
    else $error("sequencer not idle after done");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the one-wire byte master: tick stimulus, bus model, result check.
module tb;

  // Operation lengths in bus ticks, derived from the package timing.
  localparam int SLOT_LEN    = int'(owbm_pkg::SLOT_LAST) + 1;
  localparam int RESET_LEN   = int'(owbm_pkg::RST_LAST) + 1;
  localparam int BYTE_LEN    = 8 * SLOT_LEN;
  // Ticks queued for the write that closes the run: its first four bit slots.
  localparam int WRITE_PART  = 4 * SLOT_LEN;
  // Long receiver hold-off: where it starts and how long it lasts.
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 64;
  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT = 1000;
  // Cycles to wait after the last result, covering the two-stage latency.
  localparam int SETTLE      = 8;

  // One tick to send; drain holds it back until every earlier result is in.
  typedef struct {
    owbm_pkg::req_t req;
    bit             drain;
  } tick_t;

  logic clk = 1'b0;
  logic rst;

  owbm_req_if req_ch ();
  owbm_res_if res_ch ();

  one_wire_byte_master_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus, expectations and bookkeeping.
  tick_t          tick_q[$];
  owbm_pkg::res_t bus_outputs_q[$];
  int    total_ticks;
  int    sent_cnt = 0;
  int    got_cnt = 0;
  int    fail_cnt = 0;
  int    done_cnt = 0;
  int    reject_cnt = 0;
  int    low_cnt = 0;

  // Generator-side view of when the bus is free again, in tick numbers.
  int    gen_tick = 0;
  int    busy_until = 0;

  // Bus master model state.
  owbm_pkg::op_kind_t m_op = owbm_pkg::OP_IDLE;
  logic [2:0]   m_bit = '0;
  logic [9:0]   m_timer = '0;
  logic [7:0]   m_shift = '0;
  logic         m_presence = 1'b0;
  logic [7:0]   m_rx = '0;

  // Handshake pacing.
  int    req_gap = 0;
  int    rcv_stall = 0;
  int    hold_left = 0;
  bit    hold_used = 1'b0;
  bit    send_calm = 1'b0;
  bit    rcv_calm = 1'b0;
  int    quiet = 0;

  // Advance the bus master by one tick and return what it shows on that tick.
  function automatic owbm_pkg::res_t next_bus_outputs(owbm_pkg::req_t r);
    owbm_pkg::res_t o;
    logic [9:0]     t;
    bit             restart;
    bit             fin;
    o = '0;
    restart = 1'b0;
    fin = 1'b0;
    if (m_op != owbm_pkg::OP_IDLE) begin
      // Busy: refuse any new request, keep the running one going.
      if (r.action != owbm_pkg::OP_IDLE) o.rejected = 1'b1;
    end else if (r.action != owbm_pkg::OP_IDLE) begin
      m_op = owbm_pkg::op_kind_t'(r.action);
      m_timer = '0;
      m_bit = '0;
      m_shift = (r.action == owbm_pkg::OP_WRITE) ? r.tx_byte : 8'h00;
    end
    if (m_op != owbm_pkg::OP_IDLE) begin
      o.busy_res = 1'b1;
      t = m_timer;
      if (m_op == owbm_pkg::OP_RESET) begin
        o.drive_low = (t < owbm_pkg::RST_LOW_TICKS);
        if (t == owbm_pkg::RST_SAMPLE) m_presence = ~r.line_level;
        if (t >= owbm_pkg::RST_LAST) fin = 1'b1;
      end else begin
        if (m_op == owbm_pkg::OP_WRITE) begin
          o.drive_low = m_shift[0] ? (t < owbm_pkg::SHORT_TICKS)
                                   : (t < owbm_pkg::LONG_LOW_TICKS);
        end else begin
          o.drive_low = (t < owbm_pkg::SHORT_TICKS);
          if (t == owbm_pkg::READ_SAMPLE) m_shift = {r.line_level, m_shift[7:1]};
        end
        if (t >= owbm_pkg::SLOT_LAST) begin
          if (m_op == owbm_pkg::OP_WRITE) m_shift = m_shift >> 1;
          if (m_bit >= owbm_pkg::LAST_BIT) begin
            fin = 1'b1;
            if (m_op == owbm_pkg::OP_READ) m_rx = m_shift;
          end else begin
            m_bit = m_bit + 3'd1;
            m_timer = '0;
            restart = 1'b1;
          end
        end
      end
      o.done_res = fin;
      if (fin) begin
        m_op = owbm_pkg::OP_IDLE;
        m_bit = '0;
        m_timer = '0;
      end else if (!restart) begin
        m_timer = m_timer + 10'd1;
      end
    end
    o.presence = m_presence;
    o.rx_byte = m_rx;
    return o;
  endfunction

  function automatic int op_len(logic [1:0] act);
    return (act == owbm_pkg::OP_RESET) ? RESET_LEN : BYTE_LEN;
  endfunction

  // Queue one tick and track when a request it carries would free the bus.
  task automatic push_tick(logic [1:0] act, logic [7:0] tx, logic line, bit drain);
    tick_q.push_back('{req: '{action: act, tx_byte: tx, line_level: line}, drain: drain});
    if (act != owbm_pkg::OP_IDLE && gen_tick >= busy_until) busy_until = gen_tick + op_len(act);
    gen_tick++;
  endtask

  task automatic idle_ticks(int n);
    for (int i = 0; i < n; i++) begin
      push_tick(owbm_pkg::OP_IDLE, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  // Queue an operation, cut to at most len ticks. data is the write byte, the
  // read bits seen on the line, or (bit 0) the line level at the presence
  // sample of a reset. poke_pct adds requests while busy; poke_last puts one
  // on the last queued tick.
  task automatic run_op(owbm_pkg::op_kind_t kind, logic [7:0] data, int len, int poke_pct,
                        bit poke_last, bit drain);
    int         n;
    logic       line;
    logic [1:0] act;
    logic [7:0] tx;
    if (gen_tick < busy_until) idle_ticks(busy_until - gen_tick);
    n = op_len(kind);
    if (len < n) n = len;
    for (int i = 0; i < n; i++) begin
      line = 1'($urandom_range(0, 1));
      if (kind == owbm_pkg::OP_RESET && i == int'(owbm_pkg::RST_SAMPLE)) line = data[0];
      if (kind == owbm_pkg::OP_READ && (i % SLOT_LEN) == int'(owbm_pkg::READ_SAMPLE)) begin
        line = data[i / SLOT_LEN];
      end
      act = owbm_pkg::OP_IDLE;
      tx = 8'($urandom);
      if (i == 0) begin
        act = kind;
        if (kind == owbm_pkg::OP_WRITE) tx = data;
      end else if ($urandom_range(0, 99) < poke_pct) begin
        act = 2'($urandom_range(1, 3));
      end
      if (poke_last && i == n - 1) act = 2'($urandom_range(1, 3));
      push_tick(act, tx, line, drain && i == 0);
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Request driver: offer ticks from tick_q, model each one as it is taken,
  // and idle for a random number of cycles between ticks.
  always @(posedge clk) begin : driver
    bit    took;
    int    sent_now;
    int    g;
    tick_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap <= 0;
    end else begin
      took = req_ch.valid && req_ch.ready;
      sent_now = sent_cnt;
      if (took) begin
        bus_outputs_q.push_back(next_bus_outputs(req_ch.payload));
        sent_now = sent_cnt + 1;
        sent_cnt <= sent_now;
        // Switch between gapped and back-to-back stretches now and then.
        if (sent_now % 256 == 0) send_calm = ($urandom_range(0, 2) == 0);
      end
      // Hold an offered tick until it is taken.
      if (!(req_ch.valid && !took)) begin
        g = took ? (send_calm ? 0 : $urandom_range(0, 4)) : req_gap;
        if (g > 0) begin
          req_ch.valid <= 1'b0;
          req_gap <= g - 1;
        end else if (tick_q.size() == 0) begin
          req_ch.valid <= 1'b0;
        end else if (tick_q[0].drain && got_cnt != sent_now) begin
          // Pause the sender until every result so far has come back.
          req_ch.valid <= 1'b0;
        end else begin
          nxt = tick_q.pop_front();
          req_ch.payload <= nxt.req;
          req_ch.valid <= 1'b1;
        end
      end
    end
  end

  // Result monitor: compare each result with the oldest expectation and
  // stall ready at random, with one long hold-off that backs up the block.
  always @(posedge clk) begin : monitor
    owbm_pkg::res_t want;
    owbm_pkg::res_t got;
    int   s;
    if (rst) begin
      res_ch.ready <= 1'b0;
      rcv_stall <= 0;
    end else begin
      s = rcv_stall;
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.payload;
        // Only ticks taken at an earlier edge can have a result by now.
        if (got_cnt >= sent_cnt || bus_outputs_q.size() == 0) begin
          $error("result with no tick outstanding: %p", got);
          fail_cnt++;
        end else begin
          want = bus_outputs_q.pop_front();
          check_field("drive_low", want.drive_low, got.drive_low);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("presence", want.presence, got.presence);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("rejected", want.rejected, got.rejected);
          done_cnt += want.done_res;
          reject_cnt += want.rejected;
          low_cnt += want.drive_low;
          got_cnt <= got_cnt + 1;
          if ((got_cnt + 1) % 256 == 0) rcv_calm = ($urandom_range(0, 2) == 0);
        end
        s = rcv_calm ? 0 : $urandom_range(0, 4);
        if (!hold_used && got_cnt >= HOLD_AT) begin
          hold_used = 1'b1;
          hold_left = HOLD_LEN;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (s > 0) begin
        res_ch.ready <= 1'b0;
        rcv_stall <= s - 1;
      end else begin
        res_ch.ready <= 1'b1;
        rcv_stall <= 0;
      end
    end
  end

  // Watchdog: end the run if no handshake happens on either side for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $error("no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    res_ch.ready = 1'b0;

    // A few idle ticks, a full read with requests while busy including one on
    // the completing tick, then a write requested on the very tick after
    // completion (sender drained first) that runs through its first four slots.
    idle_ticks(3);
    run_op(owbm_pkg::OP_READ, 8'($urandom), BYTE_LEN, 3, 1'b1, 1'b0);
    run_op(owbm_pkg::OP_WRITE, 8'hA5, WRITE_PART, 4, 1'b0, 1'b1);
    idle_ticks(3);
    total_ticks = tick_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (got_cnt < total_ticks) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (bus_outputs_q.size() != 0) begin
      $error("%0d expected results never arrived", bus_outputs_q.size());
      fail_cnt++;
    end

    $display("Covered %0d bus ticks: %0d operations completed, %0d requests refused while busy,",
             got_cnt, done_cnt, reject_cnt);
    $display("%0d ticks with the line pulled low, %0d mismatches.", low_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
